// ===== sv/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants, codes and controller/datapath interface types for the
// go-back-n sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SEQ_BITS   = 16;
  localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
  localparam int WIN_BITS   = 5;
  localparam int TMO_BITS   = 16;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [TMO_BITS-1:0] tmo_t;

  localparam seq_t SEQ_MAX = {SEQ_BITS{1'b1}};

  // input opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [1:0] REG_TOTAL_PACKETS = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [WIN_BITS-1:0] WINDOW_SIZE_RST   = WIN_BITS'(4);
  localparam seq_t                TOTAL_PACKETS_RST = SEQ_BITS'(15);
  localparam tmo_t                TIMEOUT_TICKS_RST = TMO_BITS'(2000);

  typedef struct packed {
    logic latch;   // capture the input word
    logic exec;    // apply ack or tick update
    logic fill;    // set up the window fill range
    logic emit;    // load one send into the output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       ack_stale;
    logic       more;       // sends remain in the current range
    logic       last_send;  // the pending send is the final one
    logic       out_free;
  } stat_t;

endpackage

// ===== sv/go_back_n_sender.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-back-n ARQ sender: start, cumulative ack and tick words in, one word
// out for every data packet to be sent or resent.
// ----------------------------------------------------------------------------
// flow: an accepted input word is latched, applied in the exec state and, for a
//   start or fresh ack, turned into a fill range; the send words, up to 16, then
//   go to the output register one per cycle while the output is not stalled
//   (a tick skips the fill state); a stale ack or opcode 3 sends nothing; the
//   one-at-a-time controller takes no new input word until its sends are done
// reset: rst clears base, next, disarms all slot timers, loads window 4, total 15, timeout 2000
module go_back_n_sender (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // ack_seq
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // send_seq
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // is_retransmit, all_acked
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gbn_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  is_retransmit;
  logic  all_acked;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbn_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_opcode     (s_tuser),
    .in_ack_seq    (s_tdata[SEQ_BITS-1:0]),
    .cmd           (cmd),
    .stat          (stat),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .send_seq      (m_tdata),
    .is_retransmit (is_retransmit),
    .last          (m_tlast),
    .all_acked     (all_acked)
  );

  assign m_tuser = {all_acked, is_retransmit};

endmodule

// ===== sv/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencing state machine: accepts one input word, steps the datapath
// through update, fill and send phases as its opcode needs, then returns to idle.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  gbn_pkg::stat_t stat,
  output gbn_pkg::cmd_t  cmd
);
  import gbn_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_FILL = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (stat.opcode)
          OP_START: state_next = ST_FILL;
          OP_ACK:   state_next = stat.ack_stale ? ST_IDLE : ST_FILL;
          OP_TICK:  state_next = ST_EMIT;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_FILL: begin
        cmd.fill   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.more) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_send) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/gbn_datapath.sv =====
// ----------------------------------------------------------------------------
// gbn_datapath
// Window base, next sequence, per-slot timers, configuration registers and
// the output register of the go-back-n sender.
// ----------------------------------------------------------------------------
module gbn_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [1:0]            in_opcode,
  input  gbn_pkg::seq_t         in_ack_seq,
  input  gbn_pkg::cmd_t         cmd,
  output gbn_pkg::stat_t        stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output gbn_pkg::seq_t         send_seq,
  output logic                  is_retransmit,
  output logic                  last,
  output logic                  all_acked
);
  import gbn_pkg::*;

  logic [WIN_BITS-1:0] window_size;
  seq_t                total_packets;
  tmo_t                timeout_ticks;

  seq_t       window_base;
  seq_t       next_to_send;
  seq_t       cur;
  seq_t       stop;
  logic       retx;
  logic [1:0] op_q;
  seq_t       ack_q;

  logic [MAX_WINDOW-1:0] slot_armed;
  tmo_t                  slot_countdown [MAX_WINDOW];

  logic [WIN_BITS-1:0]   win_eff;
  tmo_t                  tmo_eff;
  seq_t                  lim;
  logic [SEQ_BITS:0]     win_end;
  seq_t                  stop_calc;
  seq_t                  new_base;
  seq_t                  clr_top;
  seq_t                  clr_cnt;
  logic                  ack_stale;
  logic [MAX_WINDOW-1:0] clr_mask;
  logic [MAX_WINDOW-1:0] expired;
  logic                  fire;
  tmo_t                  cd_dec [MAX_WINDOW];
  logic                  out_free;
  logic [SLOT_BITS-1:0]  cur_slot;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (window_size == '0) begin
      win_eff = WIN_BITS'(1);
    end else if (window_size > WIN_BITS'(MAX_WINDOW)) begin
      win_eff = WIN_BITS'(MAX_WINDOW);
    end else begin
      win_eff = window_size;
    end
  end

  assign tmo_eff   = (timeout_ticks == '0) ? TMO_BITS'(1) : timeout_ticks;
  assign lim       = (total_packets < SEQ_MAX) ? total_packets : SEQ_MAX;
  assign win_end   = {1'b0, window_base} + (SEQ_BITS + 1)'(win_eff);
  assign stop_calc = (win_end < {1'b0, lim}) ? win_end[SEQ_BITS-1:0] : lim;

  // cumulative ack: new base and the span of slots it retires
  assign ack_stale = (ack_q < window_base);
  assign new_base  = (ack_q < SEQ_MAX) ? (ack_q + SEQ_BITS'(1)) : SEQ_MAX;
  assign clr_top   = (next_to_send < new_base) ? next_to_send : new_base;
  assign clr_cnt   = clr_top - window_base;

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      logic [SLOT_BITS-1:0] off;
      off = SLOT_BITS'(i) - window_base[SLOT_BITS-1:0];
      clr_mask[i] = (SEQ_BITS'(off) < clr_cnt);
      expired[i]  = slot_armed[i] && (slot_countdown[i] <= TMO_BITS'(1));
      cd_dec[i]   = (slot_countdown[i] > TMO_BITS'(1)) ?
                    (slot_countdown[i] - TMO_BITS'(1)) : '0;
    end
  end

  assign fire     = |expired;
  assign out_free = !m_tvalid || m_tready;
  assign cur_slot = cur[SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_SIZE_RST;
      total_packets <= TOTAL_PACKETS_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
      window_base   <= '0;
      next_to_send  <= '0;
      slot_armed    <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WINDOW_SIZE:   window_size   <= cfg_data[WIN_BITS-1:0];
          REG_TOTAL_PACKETS: total_packets <= cfg_data[SEQ_BITS-1:0];
          REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TMO_BITS-1:0];
          default: ;
        endcase
      end

      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cmd.exec) begin
        unique case (op_q)
          OP_ACK: begin
            if (!ack_stale) begin
              slot_armed  <= slot_armed & ~clr_mask;
              window_base <= new_base;
              if (next_to_send < new_base) begin
                next_to_send <= new_base;
              end
            end
          end
          OP_TICK: begin
            if (fire) begin
              slot_armed   <= '0;
              next_to_send <= (window_base < stop_calc) ? stop_calc : window_base;
            end
          end
          default: ;
        endcase
      end

      if (cmd.fill) begin
        if (next_to_send < stop_calc) begin
          next_to_send <= stop_calc;
        end
      end

      if (cmd.emit) begin
        slot_armed[cur_slot] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= in_opcode;
      ack_q <= in_ack_seq;
    end

    if (cmd.exec && op_q == OP_TICK) begin
      if (fire) begin
        cur  <= window_base;
        stop <= stop_calc;
        retx <= 1'b1;
      end else begin
        // empty range, nothing to send
        cur  <= window_base;
        stop <= window_base;
        for (int i = 0; i < MAX_WINDOW; i++) begin
          if (slot_armed[i]) begin
            slot_countdown[i] <= cd_dec[i];
          end
        end
      end
    end

    if (cmd.fill) begin
      cur  <= next_to_send;
      stop <= stop_calc;
      retx <= 1'b0;
    end

    if (cmd.emit) begin
      send_seq                 <= cur;
      is_retransmit            <= retx;
      last                     <= (cur + SEQ_BITS'(1)) == stop;
      all_acked                <= (window_base >= lim);
      cur                      <= cur + SEQ_BITS'(1);
      slot_countdown[cur_slot] <= tmo_eff;
    end
  end

  always_comb begin
    stat.opcode    = op_q;
    stat.ack_stale = ack_stale;
    stat.more      = (cur < stop);
    stat.last_send = (cur + SEQ_BITS'(1)) == stop;
    stat.out_free  = out_free;
  end

endmodule
